[rtl/scpf_pkg.sv]
// ----------------------------------------------------------------------------
// scpf_pkg
// Constants and slot codes for the sensor command packet framer.
// ----------------------------------------------------------------------------
package scpf_pkg;

  // Frame constants
  localparam logic [7:0]  START_HI       = 8'hEF;
  localparam logic [7:0]  START_LO       = 8'h01;
  localparam logic [7:0]  PACKET_CMD     = 8'h01;
  localparam logic [15:0] LEN_EXTRA      = 16'd3;
  localparam logic [31:0] ADDR_RESET     = 32'hFFFF_FFFF;
  localparam int          MAX_PARAMS_DEF = 32;

  // Input actions
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_PARAM = 1'b1;

  // Register map (word index)
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  // Byte slots within a frame
  typedef logic [3:0] slot_t;
  localparam slot_t SLOT_START_HI = 4'd0;
  localparam slot_t SLOT_START_LO = 4'd1;
  localparam slot_t SLOT_ADDR_3   = 4'd2;
  localparam slot_t SLOT_ADDR_2   = 4'd3;
  localparam slot_t SLOT_ADDR_1   = 4'd4;
  localparam slot_t SLOT_ADDR_0   = 4'd5;
  localparam slot_t SLOT_PID      = 4'd6;
  localparam slot_t SLOT_LEN_HI   = 4'd7;
  localparam slot_t SLOT_LEN_LO   = 4'd8;
  localparam slot_t SLOT_DATA     = 4'd9;
  localparam slot_t SLOT_SUM_HI   = 4'd10;
  localparam slot_t SLOT_SUM_LO   = 4'd11;

endpackage

[rtl/sensor_command_packet_framer.sv]
// ----------------------------------------------------------------------------
// sensor_command_packet_framer
// Builds command frames for a serial sensor module, one byte per output beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tdata: instruction, param_count,
//          |     |                     |   param_byte; tuser: action
//  m_*     | out | m_tvalid / m_tready | tdata: frame_byte; tlast: run_last;
//          |     |                     |   tuser: frame_end
//  apb     | in  | psel/penable/pready | device_address at byte address 0
//
// An input beat is decoded into a descriptor register, which then
// emits one byte per cycle: 10 or 12 bytes for a begin, 1 or 3 for a parameter,
// so the output port sets the rate. A new input beat is taken while the last
// byte of the previous descriptor leaves. Ignored parameter beats are dropped.
// Reset is synchronous; it closes any frame and empties the descriptor.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer #(
  parameter int MAX_PARAMS = scpf_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] instruction, [13:8] param_count,
                                 // [21:14] param_byte, [23:22] zero
  input  logic        s_tuser,   // [0] action
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] frame_byte
  output logic        m_tlast,   // run_last
  output logic        m_tuser,   // [0] frame_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scpf_pkg::*;

  // registers
  logic [31:0] device_address;
  logic        in_frame;
  logic [5:0]  params_left;
  logic [15:0] running_sum;

  logic        d_valid;
  slot_t       d_pos;
  logic        d_close;
  logic [7:0]  d_len_hi;
  logic [7:0]  d_len_lo;
  logic [7:0]  d_data;
  logic [15:0] d_sum;

  // input fields
  logic        action;
  logic [7:0]  instruction;
  logic [5:0]  param_count;
  logic [7:0]  param_byte;

  logic        in_acc;
  logic        out_acc;
  logic        run_last;
  logic [5:0]  count_sat;
  logic [15:0] len;
  logic [15:0] begin_sum;
  logic [15:0] param_sum;
  logic        param_ok;
  logic        param_close;

  assign action      = s_tuser;
  assign instruction = s_tdata[7:0];
  assign param_count = s_tdata[13:8];
  assign param_byte  = s_tdata[21:14];

  // APB port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? device_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_DEVICE_ADDRESS) begin
      device_address <= pwdata;
    end
  end

  // handshakes
  assign run_last = (d_pos == (d_close ? SLOT_SUM_LO : SLOT_DATA));
  assign out_acc  = d_valid && m_tready;
  assign s_tready = !d_valid || (m_tready && run_last);
  assign in_acc   = s_tvalid && s_tready;

  // item decode
  assign count_sat   = (int'(param_count) > MAX_PARAMS) ? 6'(MAX_PARAMS) : param_count;
  assign len         = 16'(count_sat) + LEN_EXTRA;
  assign begin_sum   = 16'(PACKET_CMD) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(instruction);
  assign param_sum   = running_sum + 16'(param_byte);
  assign param_ok    = in_frame && (params_left != 6'd0);
  assign param_close = (params_left == 6'd1);

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      params_left <= 6'd0;
      running_sum <= 16'd0;
    end else if (in_acc) begin
      if (action == ACT_BEGIN) begin
        in_frame    <= (count_sat != 6'd0);
        params_left <= count_sat;
        running_sum <= begin_sum;
      end else if (param_ok) begin
        in_frame    <= !param_close;
        params_left <= params_left - 6'd1;
        running_sum <= param_sum;
      end
    end
  end

  // descriptor: loaded on a producing beat, stepped per output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      d_pos   <= SLOT_START_HI;
    end else if (in_acc && (action == ACT_BEGIN || param_ok)) begin
      d_valid <= 1'b1;
      d_pos   <= (action == ACT_BEGIN) ? SLOT_START_HI : SLOT_DATA;
    end else if (out_acc) begin
      if (run_last) begin
        d_valid <= 1'b0;
      end else begin
        d_pos <= d_pos + 4'd1;
      end
    end
  end

  // descriptor payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (action == ACT_BEGIN) begin
        d_close  <= (count_sat == 6'd0);
        d_len_hi <= len[15:8];
        d_len_lo <= len[7:0];
        d_data   <= instruction;
        d_sum    <= begin_sum;
      end else if (param_ok) begin
        d_close  <= param_close;
        d_data   <= param_byte;
        d_sum    <= param_sum;
      end
    end
  end

  // output byte select
  always_comb begin
    case (d_pos)
      SLOT_START_HI: m_tdata = START_HI;
      SLOT_START_LO: m_tdata = START_LO;
      SLOT_ADDR_3:   m_tdata = device_address[31:24];
      SLOT_ADDR_2:   m_tdata = device_address[23:16];
      SLOT_ADDR_1:   m_tdata = device_address[15:8];
      SLOT_ADDR_0:   m_tdata = device_address[7:0];
      SLOT_PID:      m_tdata = PACKET_CMD;
      SLOT_LEN_HI:   m_tdata = d_len_hi;
      SLOT_LEN_LO:   m_tdata = d_len_lo;
      SLOT_DATA:     m_tdata = d_data;
      SLOT_SUM_HI:   m_tdata = d_sum[15:8];
      SLOT_SUM_LO:   m_tdata = d_sum[7:0];
      default:       m_tdata = 8'd0;
    endcase
  end

  assign m_tvalid = d_valid;
  assign m_tlast  = run_last;
  assign m_tuser  = d_close && (d_pos == SLOT_SUM_LO);

endmodule
